// ===== rtl/tknt_pkg.sv =====
// ============================================================================
// tknt_pkg
// Shared types and constants for the streaming top-K nearest-to-target block.
// ============================================================================
package tknt_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int INDEX_BITS    = 16;
    localparam int DIST_BITS     = VALUE_BITS + 1;
    localparam int MAX_K_DEFAULT = 16;
    localparam int LIMIT_BITS    = 5;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 5;
    localparam int CFG_IDX_W     = 3;

    localparam logic [LIMIT_BITS-1:0] KEEP_LIMIT_RESET = LIMIT_BITS'(10);

    // register indexes (byte address = 4 * index)
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALUE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_SELECT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_SECOND = 3'd5;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] cos_value;
        logic signed [VALUE_BITS-1:0] dist_value;
        logic [INDEX_BITS-1:0]        first_word;
        logic [INDEX_BITS-1:0]        second_word;
        logic                         last_item;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value_out;
        logic [INDEX_BITS-1:0]        out_first_word;
        logic [INDEX_BITS-1:0]        out_second_word;
        logic                         last_result;
        logic                         empty_flag;
    } result_t;

endpackage

// ===== rtl/top_k_nearest_to_target_core.sv =====
// ============================================================================
// top_k_nearest_to_target_core
// Keeps up to keep-limit (at most MAX_K) entries closest to a target in a
// sorted register array and emits them closest-first on the last item of a run.
// ============================================================================
// Throughput: one item per cycle, but a last item waits at the insert
//   stage while the previous run's results are still draining. Insertion
//   is a parallel compare and shift. Results leave the drain buffer through
//   the output register, one result per cycle while out_ready is high.
// Reset: clears the store, the pipeline and the output; registers take their
//   documented reset values.
module top_k_nearest_to_target_core
    import tknt_pkg::*;
#(
    parameter int MAX_K = MAX_K_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // item input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  item_t                 in_data,
    // result output
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               out_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(MAX_K + 1);
    localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int LIM_W = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;

    // configuration registers
    logic signed [VALUE_BITS-1:0] target_value_reg;
    logic [LIMIT_BITS-1:0]        keep_limit_reg;
    logic                         measure_select_reg;
    logic                         exclude_enable_reg;
    logic [INDEX_BITS-1:0]        exclude_first_reg;
    logic [INDEX_BITS-1:0]        exclude_second_reg;

    // input stage
    logic  s1_valid_reg;
    item_t s1_item_reg;

    // insert stage
    logic                         p_valid_reg;
    logic signed [VALUE_BITS-1:0] p_value_reg;
    logic [DIST_BITS-1:0]         p_dist_reg;
    logic [INDEX_BITS-1:0]        p_first_reg;
    logic [INDEX_BITS-1:0]        p_second_reg;
    logic                         p_last_reg;
    logic                         p_skip_reg;

    // sorted store
    logic signed [VALUE_BITS-1:0] kept_value_reg  [MAX_K];
    logic [DIST_BITS-1:0]         kept_dist_reg   [MAX_K];
    logic [INDEX_BITS-1:0]        kept_first_reg  [MAX_K];
    logic [INDEX_BITS-1:0]        kept_second_reg [MAX_K];
    logic [CNT_W-1:0]             count_reg;

    // drain buffer, shifts toward entry 0
    logic signed [VALUE_BITS-1:0] drain_value_reg  [MAX_K];
    logic [INDEX_BITS-1:0]        drain_first_reg  [MAX_K];
    logic [INDEX_BITS-1:0]        drain_second_reg [MAX_K];
    logic [CNT_W-1:0]             drain_cnt_reg;
    logic                         drain_empty_reg;

    // output register
    logic    out_valid_reg;
    result_t out_data_reg;

    // combinational
    logic                         cfg_write;
    logic [CFG_IDX_W-1:0]         cfg_idx;
    logic                         drain_busy;
    logic                         p_fire;
    logic                         p_ready;
    logic                         s1_fire;
    logic                         in_fire;
    logic                         load_out;
    logic signed [VALUE_BITS-1:0] s1_value;
    logic [DIST_BITS-1:0]         diff_tv;
    logic [DIST_BITS-1:0]         diff_vt;
    logic [DIST_BITS-1:0]         s1_dist;
    logic                         s1_skip;
    logic [LIM_W-1:0]             klim_ext;
    logic [CNT_W-1:0]             lim;
    logic [CNT_W-1:0]             cnt_eff;
    logic [IDX_W-1:0]             lim_m1;
    logic                         full;
    logic [MAX_K-1:0]             behind;
    logic [MAX_K-1:0]             prev_behind;
    logic                         do_ins;
    logic [CNT_W-1:0]             cnt_after;
    logic signed [VALUE_BITS-1:0] ins_value  [MAX_K];
    logic [DIST_BITS-1:0]         ins_dist   [MAX_K];
    logic [INDEX_BITS-1:0]        ins_first  [MAX_K];
    logic [INDEX_BITS-1:0]        ins_second [MAX_K];

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[CFG_ADDR_W-1:2];

    always_comb
    begin
        unique case (cfg_idx)
            CFG_TARGET_VALUE:   prdata = CFG_DATA_W'(unsigned'(target_value_reg));
            CFG_KEEP_LIMIT:     prdata = CFG_DATA_W'(keep_limit_reg);
            CFG_MEASURE_SELECT: prdata = CFG_DATA_W'(measure_select_reg);
            CFG_EXCLUDE_ENABLE: prdata = CFG_DATA_W'(exclude_enable_reg);
            CFG_EXCLUDE_FIRST:  prdata = CFG_DATA_W'(exclude_first_reg);
            CFG_EXCLUDE_SECOND: prdata = CFG_DATA_W'(exclude_second_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------------
    assign drain_busy = (drain_cnt_reg != '0) || drain_empty_reg;
    assign p_fire     = p_valid_reg && !(p_last_reg && drain_busy);
    assign p_ready    = !p_valid_reg || p_fire;
    assign s1_fire    = s1_valid_reg && p_ready;
    assign in_ready   = !s1_valid_reg || p_ready;
    assign in_fire    = in_valid && in_ready;
    assign load_out   = drain_busy && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // ------------------------------------------------------------------------
    // distance to target
    // ------------------------------------------------------------------------
    assign s1_value = measure_select_reg ? s1_item_reg.dist_value : s1_item_reg.cos_value;
    assign diff_tv  = {target_value_reg[VALUE_BITS-1], target_value_reg}
                    - {s1_value[VALUE_BITS-1], s1_value};
    assign diff_vt  = {s1_value[VALUE_BITS-1], s1_value}
                    - {target_value_reg[VALUE_BITS-1], target_value_reg};
    assign s1_dist  = diff_tv[DIST_BITS-1] ? diff_vt : diff_tv;
    assign s1_skip  = exclude_enable_reg
                    && (s1_item_reg.first_word == exclude_first_reg)
                    && (s1_item_reg.second_word == exclude_second_reg);

    // ------------------------------------------------------------------------
    // limit clamp and insertion
    // ------------------------------------------------------------------------
    assign klim_ext = LIM_W'(keep_limit_reg);

    always_comb
    begin
        if (klim_ext == '0)
            lim = CNT_W'(1);
        else if (klim_ext > LIM_W'(MAX_K))
            lim = CNT_W'(MAX_K);
        else
            lim = CNT_W'(klim_ext);
    end

    assign cnt_eff = (count_reg > lim) ? lim : count_reg;
    assign full    = (cnt_eff == lim);
    assign lim_m1  = IDX_W'(lim - CNT_W'(1));

    // behind[i]: slot i sits at or after the insertion point
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            behind[i] = !((CNT_W'(i) < cnt_eff) && (kept_dist_reg[i] <= p_dist_reg));
        end
        prev_behind[0] = 1'b0;
        for (int i = 1; i < MAX_K; i++)
        begin
            prev_behind[i] = behind[i-1];
        end
    end

    assign do_ins    = p_fire && !p_skip_reg && (!full || behind[lim_m1]);
    assign cnt_after = (do_ins && !full) ? cnt_eff + CNT_W'(1) : cnt_eff;

    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            ins_value[i]  = kept_value_reg[i];
            ins_dist[i]   = kept_dist_reg[i];
            ins_first[i]  = kept_first_reg[i];
            ins_second[i] = kept_second_reg[i];
        end
        if (do_ins)
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                if (behind[i] && !prev_behind[i])
                begin
                    ins_value[i]  = p_value_reg;
                    ins_dist[i]   = p_dist_reg;
                    ins_first[i]  = p_first_reg;
                    ins_second[i] = p_second_reg;
                end
            end
            for (int i = 1; i < MAX_K; i++)
            begin
                if (prev_behind[i])
                begin
                    ins_value[i]  = kept_value_reg[i-1];
                    ins_dist[i]   = kept_dist_reg[i-1];
                    ins_first[i]  = kept_first_reg[i-1];
                    ins_second[i] = kept_second_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_value_reg   <= '0;
            keep_limit_reg     <= KEEP_LIMIT_RESET;
            measure_select_reg <= 1'b0;
            exclude_enable_reg <= 1'b0;
            exclude_first_reg  <= '0;
            exclude_second_reg <= '0;
            s1_valid_reg       <= 1'b0;
            p_valid_reg        <= 1'b0;
            count_reg          <= '0;
            drain_cnt_reg      <= '0;
            drain_empty_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_idx)
                    CFG_TARGET_VALUE:   target_value_reg   <= signed'(pwdata[VALUE_BITS-1:0]);
                    CFG_KEEP_LIMIT:     keep_limit_reg     <= pwdata[LIMIT_BITS-1:0];
                    CFG_MEASURE_SELECT: measure_select_reg <= pwdata[0];
                    CFG_EXCLUDE_ENABLE: exclude_enable_reg <= pwdata[0];
                    CFG_EXCLUDE_FIRST:  exclude_first_reg  <= pwdata[INDEX_BITS-1:0];
                    CFG_EXCLUDE_SECOND: exclude_second_reg <= pwdata[INDEX_BITS-1:0];
                    default:            ;
                endcase
            end

            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                p_valid_reg <= 1'b1;
            else if (p_fire)
                p_valid_reg <= 1'b0;

            if (p_fire)
                count_reg <= p_last_reg ? '0 : cnt_after;

            if (p_fire && p_last_reg)
            begin
                drain_cnt_reg   <= cnt_after;
                drain_empty_reg <= (cnt_after == '0);
            end
            else if (load_out)
            begin
                if (drain_empty_reg)
                    drain_empty_reg <= 1'b0;
                else
                    drain_cnt_reg <= drain_cnt_reg - CNT_W'(1);
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_item_reg <= in_data;

        if (s1_fire)
        begin
            p_value_reg  <= s1_value;
            p_dist_reg   <= s1_dist;
            p_first_reg  <= s1_item_reg.first_word;
            p_second_reg <= s1_item_reg.second_word;
            p_last_reg   <= s1_item_reg.last_item;
            p_skip_reg   <= s1_skip;
        end

        for (int i = 0; i < MAX_K; i++)
        begin
            kept_value_reg[i]  <= ins_value[i];
            kept_dist_reg[i]   <= ins_dist[i];
            kept_first_reg[i]  <= ins_first[i];
            kept_second_reg[i] <= ins_second[i];
        end

        if (p_fire && p_last_reg)
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                drain_value_reg[i]  <= ins_value[i];
                drain_first_reg[i]  <= ins_first[i];
                drain_second_reg[i] <= ins_second[i];
            end
        end
        else if (load_out && !drain_empty_reg)
        begin
            for (int i = 0; i < MAX_K - 1; i++)
            begin
                drain_value_reg[i]  <= drain_value_reg[i+1];
                drain_first_reg[i]  <= drain_first_reg[i+1];
                drain_second_reg[i] <= drain_second_reg[i+1];
            end
        end

        if (load_out)
        begin
            if (drain_empty_reg)
            begin
                out_data_reg.value_out       <= '0;
                out_data_reg.out_first_word  <= '0;
                out_data_reg.out_second_word <= '0;
                out_data_reg.last_result     <= 1'b1;
                out_data_reg.empty_flag      <= 1'b1;
            end
            else
            begin
                out_data_reg.value_out       <= drain_value_reg[0];
                out_data_reg.out_first_word  <= drain_first_reg[0];
                out_data_reg.out_second_word <= drain_second_reg[0];
                out_data_reg.last_result     <= (drain_cnt_reg == CNT_W'(1));
                out_data_reg.empty_flag      <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_last_waits_for_drain: assert property (@(posedge clk) disable iff (!rst_n)
        p_fire && p_last_reg |-> !drain_busy)
        else $error("last item taken while results still draining");

    a_last_loads_drain: assert property (@(posedge clk) disable iff (!rst_n)
        p_fire && p_last_reg |=> drain_busy && (count_reg == '0))
        else $error("last item did not hand the store to the drain");

    a_insert_keeps_entry: assert property (@(posedge clk) disable iff (!rst_n)
        p_fire && !p_last_reg && !p_skip_reg |=> count_reg != '0)
        else $error("store empty after an insert");

    a_drain_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(drain_empty_reg && (drain_cnt_reg != '0)))
        else $error("empty marker with entries pending");

    a_empty_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.empty_flag |->
            out_data_reg.last_result && (out_data_reg.value_out == '0)
            && (out_data_reg.out_first_word == '0))
        else $error("malformed empty result");

endmodule

// ===== test/top_k_nearest_to_target_core_test.sv =====
// ----------------------------------------------------------------------------
// top_k_nearest_to_target_core_test
// Self-checking bench for the streaming top-K nearest-to-target block. Table
// entries go in over a valid/ready channel and kept entries are checked in
// order against a predictor that tracks the sorted store, the exclusion and
// the keep limit. Registers are set over the APB port between phases.
// ----------------------------------------------------------------------------
module top_k_nearest_to_target_core_test
    import tknt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_K = MAX_K_DEFAULT;
    localparam int SETTLE_CYCLES = 8;
    localparam int PEND_DEPTH = 64;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd6;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [DIST_BITS-1:0]         dist_gap;
        logic [INDEX_BITS-1:0]        first;
        logic [INDEX_BITS-1:0]        second;
    } kept_entry_t;

    class top_k_scoreboard;
        logic signed [VALUE_BITS-1:0] target;
        logic [LIMIT_BITS-1:0]        limit;
        logic                         use_dist;
        logic                         excl_en;
        logic [INDEX_BITS-1:0]        excl_first;
        logic [INDEX_BITS-1:0]        excl_second;
        kept_entry_t                  kept[MAX_K];
        int                           kept_count;
        result_t                      pend_buf[PEND_DEPTH];
        int                           pend_head;
        int                           pend_count;
        int                           errors;

        function new();
            target = '0;
            limit = KEEP_LIMIT_RESET;
            use_dist = 1'b0;
            excl_en = 1'b0;
            excl_first = '0;
            excl_second = '0;
            kept_count = 0;
            pend_head = 0;
            pend_count = 0;
            errors = 0;
        endfunction

        function int pending_count();
            return pend_count;
        endfunction

        function void add_expected(result_t r);
            if (pend_count == PEND_DEPTH)
            begin
                $error("expected result buffer overflow");
                errors++;
                return;
            end
            pend_buf[(pend_head + pend_count) % PEND_DEPTH] = r;
            pend_count++;
        endfunction

        function result_t take_expected();
            result_t r;
            r = pend_buf[pend_head];
            pend_head = (pend_head + 1) % PEND_DEPTH;
            pend_count--;
            return r;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TARGET_VALUE:   target = data[VALUE_BITS-1:0];
                CFG_KEEP_LIMIT:     limit = data[LIMIT_BITS-1:0];
                CFG_MEASURE_SELECT: use_dist = data[0];
                CFG_EXCLUDE_ENABLE: excl_en = data[0];
                CFG_EXCLUDE_FIRST:  excl_first = data[INDEX_BITS-1:0];
                CFG_EXCLUDE_SECOND: excl_second = data[INDEX_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [DIST_BITS-1:0] gap_to_target(logic signed [VALUE_BITS-1:0] v);
            longint t;
            longint x;
            t = longint'(target);
            x = longint'(v);
            return (t >= x) ? DIST_BITS'(t - x) : DIST_BITS'(x - t);
        endfunction

        function void note_entry(item_t it);
            int lim;
            int pos;
            int i;
            kept_entry_t ne;
            result_t r;
            lim = (limit == 0) ? 1 : ((limit > MAX_K) ? MAX_K : int'(limit));
            if (kept_count > lim)
                kept_count = lim;
            ne.value = use_dist ? it.dist_value : it.cos_value;
            ne.dist_gap = gap_to_target(ne.value);
            ne.first = it.first_word;
            ne.second = it.second_word;
            if (!(excl_en && it.first_word == excl_first && it.second_word == excl_second))
            begin
                pos = 0;
                while (pos < kept_count && kept[pos].dist_gap <= ne.dist_gap)
                    pos++;
                if (kept_count < lim)
                begin
                    for (i = kept_count; i > pos; i--)
                        kept[i] = kept[i-1];
                    kept[pos] = ne;
                    kept_count++;
                end
                else if (ne.dist_gap < kept[lim-1].dist_gap)
                begin
                    for (i = lim - 1; i > pos; i--)
                        kept[i] = kept[i-1];
                    kept[pos] = ne;
                end
            end
            if (!it.last_item)
                return;
            if (kept_count == 0)
            begin
                r = '0;
                r.last_result = 1'b1;
                r.empty_flag = 1'b1;
                add_expected(r);
            end
            for (i = 0; i < kept_count; i++)
            begin
                r.value_out = kept[i].value;
                r.out_first_word = kept[i].first;
                r.out_second_word = kept[i].second;
                r.last_result = (i == kept_count - 1);
                r.empty_flag = 1'b0;
                add_expected(r);
            end
            kept_count = 0;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pend_count == 0)
            begin
                $error("unexpected result: value_out %0d first %0d second %0d",
                       got.value_out, got.out_first_word, got.out_second_word);
                errors++;
                return;
            end
            want = take_expected();
            if (got.value_out !== want.value_out)
            begin
                $error("value_out: expected %0d, got %0d", want.value_out, got.value_out);
                errors++;
            end
            if (got.out_first_word !== want.out_first_word)
            begin
                $error("out_first_word: expected %0d, got %0d",
                       want.out_first_word, got.out_first_word);
                errors++;
            end
            if (got.out_second_word !== want.out_second_word)
            begin
                $error("out_second_word: expected %0d, got %0d",
                       want.out_second_word, got.out_second_word);
                errors++;
            end
            if (got.last_result !== want.last_result)
            begin
                $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
                errors++;
            end
            if (got.empty_flag !== want.empty_flag)
            begin
                $error("empty_flag: expected %0b, got %0b", want.empty_flag, got.empty_flag);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    item_t                 in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    result_t               out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    top_k_scoreboard sb = new();
    bit              quiet = 1'b0;
    int unsigned     cycle_count = 0;

    top_k_nearest_to_target_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_entry(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    function automatic item_t make_entry(logic [VALUE_BITS-1:0] cos, logic [VALUE_BITS-1:0] eucl,
                                         logic [INDEX_BITS-1:0] f, logic [INDEX_BITS-1:0] s,
                                         logic last);
        item_t it;
        it.cos_value = cos;
        it.dist_value = eucl;
        it.first_word = f;
        it.second_word = s;
        it.last_item = last;
        return it;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value(logic [VALUE_BITS-1:0] near,
                                                         logic [VALUE_BITS-1:0] prev);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: return near + VALUE_BITS'($urandom_range(0, 16)) - VALUE_BITS'(8);
            5: return prev;
            default: return $urandom();
        endcase
    endfunction

    // leaves in_valid high at the accepting edge; caller drives it next
    task automatic send_item(input item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic end_writes();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_all(input logic [VALUE_BITS-1:0] t, input logic [LIMIT_BITS-1:0] k,
                             input logic m, input logic en,
                             input logic [INDEX_BITS-1:0] f, input logic [INDEX_BITS-1:0] s);
        write_reg(CFG_TARGET_VALUE, t);
        write_reg(CFG_KEEP_LIMIT, CFG_DATA_W'(k));
        write_reg(CFG_MEASURE_SELECT, CFG_DATA_W'(m));
        write_reg(CFG_EXCLUDE_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_EXCLUDE_FIRST, CFG_DATA_W'(f));
        write_reg(CFG_EXCLUDE_SECOND, CFG_DATA_W'(s));
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED_INDEX, $urandom());
        end_writes();
    endtask

    task automatic random_config();
        logic [VALUE_BITS-1:0] t;
        logic [LIMIT_BITS-1:0] k;
        logic [INDEX_BITS-1:0] f;
        logic [INDEX_BITS-1:0] s;
        case ($urandom_range(0, 4))
            0: t = '0;
            1: t = 32'h7FFF_FFFF;
            2: t = 32'h8000_0000;
            3: t = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            default: t = $urandom();
        endcase
        case ($urandom_range(0, 7))
            0: k = LIMIT_BITS'(1);
            1: k = LIMIT_BITS'(16);
            2: k = ($urandom_range(0, 1) == 0) ? '0 : LIMIT_BITS'($urandom_range(17, 31));
            default: k = LIMIT_BITS'($urandom_range(1, 16));
        endcase
        if ($urandom_range(0, 1) == 0)
        begin
            f = INDEX_BITS'($urandom_range(0, 3));
            s = INDEX_BITS'($urandom_range(0, 3));
        end
        else
        begin
            f = INDEX_BITS'($urandom_range(0, 65535));
            s = INDEX_BITS'($urandom_range(0, 65535));
        end
        write_all(t, k, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), f, s);
    endtask

    task automatic random_phase(input int n_items, input bit close_run);
        item_t it;
        int run_len;
        int sent;
        int k;
        logic [VALUE_BITS-1:0] prev_cos;
        logic [VALUE_BITS-1:0] prev_dist;
        sent = 0;
        prev_cos = '0;
        prev_dist = '0;
        while (sent < n_items)
        begin
            run_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 24);
            for (k = 0; k < run_len && sent < n_items; k++)
            begin
                it.cos_value = pick_value(sb.target, prev_cos);
                it.dist_value = pick_value(sb.target, prev_dist);
                prev_cos = it.cos_value;
                prev_dist = it.dist_value;
                case ($urandom_range(0, 7))
                    0:
                    begin
                        it.first_word = sb.excl_first;
                        it.second_word = sb.excl_second;
                    end
                    1:
                    begin
                        it.first_word = sb.excl_second;
                        it.second_word = sb.excl_first;
                    end
                    2:
                    begin
                        it.first_word = INDEX_BITS'($urandom_range(0, 3));
                        it.second_word = INDEX_BITS'($urandom_range(0, 3));
                    end
                    default:
                    begin
                        it.first_word = INDEX_BITS'($urandom_range(0, 65535));
                        it.second_word = INDEX_BITS'($urandom_range(0, 65535));
                    end
                endcase
                it.last_item = (k == run_len - 1) || (close_run && sent == n_items - 1);
                if (!close_run && sent == n_items - 1)
                    it.last_item = 1'b0;
                send_item(it);
                sent++;
            end
        end
    endtask

    initial
    begin
        int ph;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: cosine, target 0, limit 10; extremes and ties
        send_item(make_entry(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h0000, 1'b0));
        send_item(make_entry(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'hFFFF, 1'b0));
        send_item(make_entry(32'h0100_0000, 32'h0000_0000, 16'd1, 16'd2, 1'b0));
        send_item(make_entry(32'hFF00_0000, $urandom(), 16'd3, 16'd4, 1'b0));
        send_item(make_entry(32'h0000_0000, $urandom(), 16'd5, 16'd6, 1'b0));
        send_item(make_entry(32'h0100_0000, $urandom(), 16'd7, 16'd8, 1'b1));
        wait_idle();

        // top target, limit 0 acts as 1, distance measure, exclusion in order only
        write_all(32'h7FFF_FFFF, 5'd0, 1'b1, 1'b1, 16'hFFFF, 16'h0000);
        send_item(make_entry($urandom(), 32'h8000_0000, 16'hFFFF, 16'h0000, 1'b0));
        send_item(make_entry($urandom(), 32'h8000_0000, 16'h0000, 16'hFFFF, 1'b0));
        send_item(make_entry($urandom(), 32'h7FFF_FFFF, 16'd9, 16'd9, 1'b0));
        send_item(make_entry($urandom(), 32'h7FFF_FFFF, 16'd10, 16'd10, 1'b0));
        send_item(make_entry($urandom(), 32'h8000_0000, 16'hFFFF, 16'h0000, 1'b1));
        wait_idle();

        // bottom target, limit above range; empty run, then limit lowered mid-run
        write_all(32'h8000_0000, 5'd31, 1'b0, 1'b1, 16'hFFFF, 16'h0000);
        send_item(make_entry($urandom(), $urandom(), 16'hFFFF, 16'h0000, 1'b1));
        send_item(make_entry(32'h7FFF_FFFF, $urandom(), 16'd1, 16'd1, 1'b0));
        repeat (4)
            send_item(make_entry($urandom(), $urandom(), INDEX_BITS'($urandom_range(0, 65535)),
                                 INDEX_BITS'($urandom_range(0, 65535)), 1'b0));
        wait_idle();
        write_reg(CFG_KEEP_LIMIT, CFG_DATA_W'(5'd2));
        end_writes();
        send_item(make_entry(32'h8000_0000, $urandom(), 16'd2, 16'd2, 1'b1));
        wait_idle();

        for (ph = 0; ph < 8; ph++)
        begin
            random_config();
            quiet = (ph % 3 == 2);
            random_phase(13, ph != 3 && ph != 6);
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
